@@ rtl/core/bc3_pkg.sv @@
package bc3_pkg;

    localparam int unsigned PIXELS      = 16;
    localparam int unsigned SLOT_W      = 4;
    localparam int unsigned AIDX_W      = 3;
    localparam int unsigned CIDX_W      = 2;
    localparam int unsigned ALPHA_LVLS  = 8;
    localparam int unsigned COLOR_LVLS  = 4;
    localparam int unsigned CHANNELS    = 3;

    localparam int unsigned LANE_NUM_W   = 16;
    localparam int unsigned LANE_RECIP_W = 17;
    localparam int unsigned LANE_PROD_W  = LANE_NUM_W + LANE_RECIP_W;

    // reciprocal multipliers: floor(x / d) == (x * RECIP) >> SHIFT over the numerator range
    localparam int unsigned DIV7_RECIP   = 4682;
    localparam int unsigned DIV5_RECIP   = 6554;
    localparam int unsigned DIV255_RECIP = 65794;
    localparam int unsigned ALPHA_SHIFT  = 15;
    localparam int unsigned COLOR_SHIFT  = 24;

    localparam int unsigned DIV7_BIAS = 3;
    localparam int unsigned DIV5_BIAS = 2;
    localparam int unsigned WEIGHT_LO = 85;
    localparam int unsigned WEIGHT_HI = 170;

    localparam logic [7:0] ALPHA_ZERO = 8'h00;
    localparam logic [7:0] ALPHA_FULL = 8'hFF;

    localparam int unsigned TDATA_IN_W  = 128;
    localparam int unsigned TDATA_OUT_W = 40;

    typedef logic [7:0] t_byte;

    typedef struct packed {
        t_byte [ALPHA_LVLS-1:0]             alpha;
        t_byte [COLOR_LVLS-1:0]             red;
        t_byte [COLOR_LVLS-1:0]             green;
        t_byte [COLOR_LVLS-1:0]             blue;
        logic  [PIXELS-1:0][AIDX_W-1:0]     aidx;
        logic  [PIXELS-1:0][CIDX_W-1:0]     cidx;
    } t_block;

    function automatic t_byte expand5(input logic [4:0] v);
        return {v, v[4:2]};
    endfunction

    function automatic t_byte expand6(input logic [5:0] v);
        return {v, v[5:4]};
    endfunction

endpackage

@@ rtl/core/bc3_blend_lane.sv @@
module bc3_blend_lane #(
    parameter int unsigned W0    = 1,
    parameter int unsigned W1    = 1,
    parameter int unsigned BIAS  = 0,
    parameter int unsigned RECIP = 1,
    parameter int unsigned SHIFT = 0
) (
    input  logic             i_clk,
    input  logic             i_en,
    input  bc3_pkg::t_byte   i_e0,
    input  bc3_pkg::t_byte   i_e1,
    output bc3_pkg::t_byte   o_quot
);
    import bc3_pkg::*;

    localparam logic [LANE_NUM_W-1:0]   W0_V    = LANE_NUM_W'(W0);
    localparam logic [LANE_NUM_W-1:0]   W1_V    = LANE_NUM_W'(W1);
    localparam logic [LANE_NUM_W-1:0]   BIAS_V  = LANE_NUM_W'(BIAS);
    localparam logic [LANE_PROD_W-1:0]  RECIP_V = LANE_PROD_W'(RECIP);

    logic [LANE_NUM_W-1:0]  n_num;
    logic [LANE_NUM_W-1:0]  r_num;
    logic [LANE_PROD_W-1:0] w_prod;

    assign n_num = W0_V * LANE_NUM_W'(i_e0) + W1_V * LANE_NUM_W'(i_e1) + BIAS_V;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_num <= n_num;
        end
    end

    assign w_prod = LANE_PROD_W'(r_num) * RECIP_V;
    assign o_quot = w_prod[SHIFT +: 8];

endmodule

@@ rtl/core/bc3_palette.sv @@
module bc3_palette (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  logic [63:0]     i_alpha_half,
    input  logic [63:0]     i_color_half,
    output logic            o_valid,
    input  logic            i_ready,
    output bc3_pkg::t_block o_blk
);
    import bc3_pkg::*;

    logic s1_load;
    logic s2_load;
    logic s2_free;

    logic   r_s1_vld;
    logic   r_s2_vld;
    t_byte  r_a0;
    t_byte  r_a1;
    t_byte  r_c0 [CHANNELS];
    t_byte  r_c1 [CHANNELS];
    logic [PIXELS-1:0][AIDX_W-1:0] r_aidx;
    logic [PIXELS-1:0][CIDX_W-1:0] r_cidx;
    t_block r_blk;
    t_block n_blk;

    t_byte in_c0 [CHANNELS];
    t_byte in_c1 [CHANNELS];
    t_byte q7 [6];
    t_byte q5 [4];
    t_byte qlo [CHANNELS];
    t_byte qhi [CHANNELS];

    assign s2_free = !r_s2_vld || i_ready;
    assign s2_load = r_s1_vld && s2_free;
    assign o_ready = !r_s1_vld || s2_load;
    assign s1_load = i_valid && o_ready;

    assign in_c0[0] = expand5(i_color_half[15:11]);
    assign in_c0[1] = expand6(i_color_half[10:5]);
    assign in_c0[2] = expand5(i_color_half[4:0]);
    assign in_c1[0] = expand5(i_color_half[31:27]);
    assign in_c1[1] = expand6(i_color_half[26:21]);
    assign in_c1[2] = expand5(i_color_half[20:16]);

    for (genvar k = 0; k < 6; k++) begin : g_div7
        bc3_blend_lane #(
            .W0(6 - k), .W1(1 + k), .BIAS(DIV7_BIAS),
            .RECIP(DIV7_RECIP), .SHIFT(ALPHA_SHIFT)
        ) u_lane (
            .i_clk(i_clk), .i_en(s1_load),
            .i_e0(i_alpha_half[7:0]), .i_e1(i_alpha_half[15:8]),
            .o_quot(q7[k])
        );
    end

    for (genvar k = 0; k < 4; k++) begin : g_div5
        bc3_blend_lane #(
            .W0(4 - k), .W1(1 + k), .BIAS(DIV5_BIAS),
            .RECIP(DIV5_RECIP), .SHIFT(ALPHA_SHIFT)
        ) u_lane (
            .i_clk(i_clk), .i_en(s1_load),
            .i_e0(i_alpha_half[7:0]), .i_e1(i_alpha_half[15:8]),
            .o_quot(q5[k])
        );
    end

    for (genvar ch = 0; ch < CHANNELS; ch++) begin : g_color
        bc3_blend_lane #(
            .W0(WEIGHT_HI), .W1(WEIGHT_LO), .BIAS(0),
            .RECIP(DIV255_RECIP), .SHIFT(COLOR_SHIFT)
        ) u_lo (
            .i_clk(i_clk), .i_en(s1_load),
            .i_e0(in_c0[ch]), .i_e1(in_c1[ch]),
            .o_quot(qlo[ch])
        );
        bc3_blend_lane #(
            .W0(WEIGHT_LO), .W1(WEIGHT_HI), .BIAS(0),
            .RECIP(DIV255_RECIP), .SHIFT(COLOR_SHIFT)
        ) u_hi (
            .i_clk(i_clk), .i_en(s1_load),
            .i_e0(in_c0[ch]), .i_e1(in_c1[ch]),
            .o_quot(qhi[ch])
        );
    end

    always_comb begin
        n_blk          = '0;
        n_blk.aidx     = r_aidx;
        n_blk.cidx     = r_cidx;
        n_blk.alpha[0] = r_a0;
        n_blk.alpha[1] = r_a1;
        if (r_a0 > r_a1) begin
            for (int k = 0; k < 6; k++) begin
                n_blk.alpha[2 + k] = q7[k];
            end
        end else begin
            for (int k = 0; k < 4; k++) begin
                n_blk.alpha[2 + k] = q5[k];
            end
            n_blk.alpha[6] = ALPHA_ZERO;
            n_blk.alpha[7] = ALPHA_FULL;
        end
        n_blk.red   = {qhi[0], qlo[0], r_c1[0], r_c0[0]};
        n_blk.green = {qhi[1], qlo[1], r_c1[1], r_c0[1]};
        n_blk.blue  = {qhi[2], qlo[2], r_c1[2], r_c0[2]};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
        end else begin
            if (s1_load) begin
                r_s1_vld <= 1'b1;
            end else if (s2_load) begin
                r_s1_vld <= 1'b0;
            end
            if (s2_load) begin
                r_s2_vld <= 1'b1;
            end else if (i_ready) begin
                r_s2_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_load) begin
            r_a0   <= i_alpha_half[7:0];
            r_a1   <= i_alpha_half[15:8];
            r_c0   <= in_c0;
            r_c1   <= in_c1;
            r_aidx <= i_alpha_half[63:16];
            r_cidx <= i_color_half[63:32];
        end
        if (s2_load) begin
            r_blk <= n_blk;
        end
    end

    assign o_valid = r_s2_vld;
    assign o_blk   = r_blk;

endmodule

@@ rtl/core/bc3_pixel_serializer.sv @@
module bc3_pixel_serializer (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  bc3_pkg::t_block             i_blk,
    output logic                        o_valid,
    input  logic                        i_ready,
    output bc3_pkg::t_byte              o_red,
    output bc3_pkg::t_byte              o_green,
    output bc3_pkg::t_byte              o_blue,
    output bc3_pkg::t_byte              o_alpha,
    output logic [bc3_pkg::SLOT_W-1:0]  o_slot,
    output logic                        o_last
);
    import bc3_pkg::*;

    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(PIXELS - 1);

    t_block              r_blk;
    logic                r_busy;
    logic [SLOT_W-1:0]   r_cnt;
    logic                r_out_vld;
    t_byte               r_red;
    t_byte               r_green;
    t_byte               r_blue;
    t_byte               r_alpha;
    logic [SLOT_W-1:0]   r_slot;
    logic                r_last;

    logic               out_free;
    logic               emit;
    logic               load;
    logic [CIDX_W-1:0]  ci;
    logic [AIDX_W-1:0]  ai;

    assign out_free = !r_out_vld || i_ready;
    assign emit     = r_busy && out_free;
    assign o_ready  = !r_busy || (out_free && r_cnt == LAST_SLOT);
    assign load     = i_valid && o_ready;

    assign ci = r_blk.cidx[r_cnt];
    assign ai = r_blk.aidx[r_cnt];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy    <= 1'b0;
            r_cnt     <= '0;
            r_out_vld <= 1'b0;
        end else begin
            if (load) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (emit) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == LAST_SLOT) begin
                    r_busy <= 1'b0;
                end
            end
            if (emit) begin
                r_out_vld <= 1'b1;
            end else if (i_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_blk <= i_blk;
        end
        if (emit) begin
            r_red   <= r_blk.red[ci];
            r_green <= r_blk.green[ci];
            r_blue  <= r_blk.blue[ci];
            r_alpha <= r_blk.alpha[ai];
            r_slot  <= r_cnt;
            r_last  <= (r_cnt == LAST_SLOT);
        end
    end

    assign o_valid = r_out_vld;
    assign o_red   = r_red;
    assign o_green = r_green;
    assign o_blue  = r_blue;
    assign o_alpha = r_alpha;
    assign o_slot  = r_slot;
    assign o_last  = r_last;

    a_idle_cnt_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_busy |-> r_cnt == '0)
        else $error("pixel counter not cleared while idle");

    a_word_in_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && r_slot != LAST_SLOT) |-> r_busy)
        else $error("block dropped before its last pixel");

    a_start_at_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_busy) |-> r_cnt == '0)
        else $error("block started at a nonzero pixel");

endmodule

@@ rtl/core/bc3_block_decoder.sv @@
// BC3 (DXT5) block decoder. Each input word is one 16-byte block; it yields sixteen
// RGBA8 output words in raster order within the 4x4 block, tlast on the sixteenth.
// The pixel serializer emits one pixel per cycle while m_axis_tready does not stall it.
// A new block is taken while the previous one is still being emitted, so blocks stream
// with no gap. From input acceptance to the first pixel, a block passes through the
// endpoint/numerator stage, the palette stage, the serializer load and the output register.
module bc3_block_decoder (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // [63:0] alpha_half, [127:64] color_half
    input  logic [bc3_pkg::TDATA_IN_W-1:0]    s_axis_tdata,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // [7:0] red, [15:8] green, [23:16] blue, [31:24] alpha, [35:32] pixel_slot, [39:36] zero
    output logic [bc3_pkg::TDATA_OUT_W-1:0]   m_axis_tdata,
    output logic                              m_axis_tlast
);
    import bc3_pkg::*;

    logic              pal_vld;
    logic              pal_rdy;
    t_block            pal_blk;
    t_byte             px_red;
    t_byte             px_green;
    t_byte             px_blue;
    t_byte             px_alpha;
    logic [SLOT_W-1:0] px_slot;

    bc3_palette u_palette (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (s_axis_tvalid),
        .o_ready      (s_axis_tready),
        .i_alpha_half (s_axis_tdata[63:0]),
        .i_color_half (s_axis_tdata[127:64]),
        .o_valid      (pal_vld),
        .i_ready      (pal_rdy),
        .o_blk        (pal_blk)
    );

    bc3_pixel_serializer u_serializer (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (pal_vld),
        .o_ready (pal_rdy),
        .i_blk   (pal_blk),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_red   (px_red),
        .o_green (px_green),
        .o_blue  (px_blue),
        .o_alpha (px_alpha),
        .o_slot  (px_slot),
        .o_last  (m_axis_tlast)
    );

    assign m_axis_tdata = {4'b0, px_slot, px_alpha, px_blue, px_green, px_red};

endmodule
